/* hdl/mhsp_pkg.sv */
// Shared types and codes for the MQTT header stream parser.
package mhsp_pkg;

    localparam int LEN_W = 28;

    localparam logic [3:0] PT_CONNECT  = 4'd1;
    localparam logic [3:0] PT_CONNACK  = 4'd2;
    localparam logic [3:0] PT_PUBLISH  = 4'd3;
    localparam logic [3:0] PT_PUBACK   = 4'd4;
    localparam logic [3:0] PT_UNSUBACK = 4'd11;

    localparam logic [3:0] ROLE_FIRST     = 4'd0;
    localparam logic [3:0] ROLE_LENGTH    = 4'd1;
    localparam logic [3:0] ROLE_STRLEN    = 4'd2;
    localparam logic [3:0] ROLE_STRBYTE   = 4'd3;
    localparam logic [3:0] ROLE_LEVEL     = 4'd4;
    localparam logic [3:0] ROLE_CFLAGS    = 4'd5;
    localparam logic [3:0] ROLE_KEEPALIVE = 4'd6;
    localparam logic [3:0] ROLE_ID        = 4'd7;
    localparam logic [3:0] ROLE_CONNACK   = 4'd8;
    localparam logic [3:0] ROLE_PAYLOAD   = 4'd9;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LEN_LONG  = 2'd1;
    localparam logic [1:0] ERR_STR_OVER  = 2'd2;
    localparam logic [1:0] ERR_HDR_SHORT = 2'd3;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic [3:0]       byte_role;
        logic [3:0]       packet_type;
        logic [3:0]       packet_flags;
        logic [LEN_W-1:0] remaining_length;
        logic [15:0]      string_length;
        logic [15:0]      packet_id;
        logic [15:0]      keepalive;
        logic             last_of_packet;
        logic [1:0]       error_code;
    } result_t;

endpackage

/* hdl/mhsp_core.sv */
// Parser state and the per-beat decode of one stream byte.
module mhsp_core
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          in_byte,
    output mhsp_pkg::result_t   res
);

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_LEN,
        PH_LENX,
        PH_STRLEN,
        PH_STR,
        PH_LEVEL,
        PH_CFLAGS,
        PH_KA,
        PH_ID,
        PH_CONNACK,
        PH_PAYLOAD,
        PH_SKIP
    } phase_t;

    phase_t                        phase_reg, phase_next, nxt;
    logic [3:0]                    type_reg, type_next;
    logic [3:0]                    flags_reg, flags_next;
    logic [mhsp_pkg::LEN_W-1:0]    left_reg, left_next;
    logic [1:0]                    shift_reg, shift_next;
    logic [15:0]                   count_reg, count_next;
    logic [15:0]                   strlen_reg, strlen_next;
    logic [15:0]                   id_reg, id_next;
    logic [15:0]                   ka_reg, ka_next;
    logic                          stuck_reg, stuck_next;
    logic [mhsp_pkg::LEN_W-1:0]    total_reg, total_next;

    logic [mhsp_pkg::LEN_W-1:0]    group;
    logic [mhsp_pkg::LEN_W-1:0]    total_sum;
    logic [mhsp_pkg::LEN_W-1:0]    left_dec;
    logic [15:0]                   count_dec;
    logic [15:0]                   strlen_full;
    logic                          in_body;
    logic [3:0]                    role;
    logic [1:0]                    err;
    logic                          last;

    function automatic phase_t header_start(input logic [3:0] ptype);
        phase_t p;
        if (ptype == mhsp_pkg::PT_CONNECT || ptype == mhsp_pkg::PT_PUBLISH)
            p = PH_STRLEN;
        else if (ptype == mhsp_pkg::PT_CONNACK)
            p = PH_CONNACK;
        else if (ptype >= mhsp_pkg::PT_PUBACK && ptype <= mhsp_pkg::PT_UNSUBACK)
            p = PH_ID;
        else
            p = PH_PAYLOAD;
        return p;
    endfunction

    function automatic phase_t after_string(input logic [3:0] ptype, input logic [1:0] qos);
        phase_t p;
        if (ptype == mhsp_pkg::PT_CONNECT)
            p = PH_LEVEL;
        else if (qos != 2'd0)
            p = PH_ID;
        else
            p = PH_PAYLOAD;
        return p;
    endfunction

    // 7-bit length group placed by its position, little-endian
    always_comb
    begin
        case (shift_reg)
            2'd0:    group = {21'd0, in_byte[6:0]};
            2'd1:    group = {14'd0, in_byte[6:0], 7'd0};
            2'd2:    group = {7'd0, in_byte[6:0], 14'd0};
            default: group = {in_byte[6:0], 21'd0};
        endcase
    end

    assign total_sum   = total_reg + group;
    assign left_dec    = (left_reg != '0) ?
                         left_reg - {{(mhsp_pkg::LEN_W-1){1'b0}}, 1'b1} : '0;
    assign count_dec   = (count_reg != '0) ? count_reg - 16'd1 : '0;
    assign strlen_full = {strlen_reg[15:8], in_byte};
    assign in_body     = (phase_reg >= PH_STRLEN) && (phase_reg <= PH_SKIP);

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        flags_next  = flags_reg;
        left_next   = left_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        strlen_next = strlen_reg;
        id_next     = id_reg;
        ka_next     = ka_reg;
        stuck_next  = stuck_reg;
        total_next  = total_reg;
        nxt         = phase_reg;
        role        = mhsp_pkg::ROLE_PAYLOAD;
        err         = mhsp_pkg::ERR_NONE;
        last        = 1'b0;

        if (stuck_reg)
        begin
            role = mhsp_pkg::ROLE_LENGTH;
            err  = mhsp_pkg::ERR_LEN_LONG;
        end
        else if (phase_reg == PH_LEN)
        begin
            role       = mhsp_pkg::ROLE_LENGTH;
            total_next = total_sum;
            if (in_byte[7])
            begin
                if (shift_reg == 2'd3)
                    phase_next = PH_LENX;
                else
                    shift_next = shift_reg + 2'd1;
            end
            else
            begin
                left_next  = total_sum;
                count_next = '0;
                if (total_sum == '0)
                begin
                    last = 1'b1;
                    if (type_reg >= mhsp_pkg::PT_CONNECT && type_reg <= mhsp_pkg::PT_UNSUBACK)
                        err = mhsp_pkg::ERR_HDR_SHORT;
                    phase_next = PH_FIRST;
                end
                else
                begin
                    phase_next = header_start(type_reg);
                end
            end
        end
        else if (phase_reg == PH_LENX)
        begin
            role       = mhsp_pkg::ROLE_LENGTH;
            err        = mhsp_pkg::ERR_LEN_LONG;
            stuck_next = 1'b1;
        end
        else if (in_body)
        begin
            left_next = left_dec;
            case (phase_reg)
                PH_STRLEN:
                begin
                    role = mhsp_pkg::ROLE_STRLEN;
                    if (count_reg == '0)
                    begin
                        strlen_next = {in_byte, 8'd0};
                        count_next  = 16'd1;
                    end
                    else
                    begin
                        strlen_next = strlen_full;
                        count_next  = '0;
                        if ({12'd0, strlen_full} > left_dec)
                        begin
                            err = mhsp_pkg::ERR_STR_OVER;
                            nxt = PH_SKIP;
                        end
                        else if (strlen_full != '0)
                        begin
                            count_next = strlen_full;
                            nxt        = PH_STR;
                        end
                        else
                        begin
                            nxt = after_string(type_reg, flags_reg[2:1]);
                        end
                    end
                end
                PH_STR:
                begin
                    role       = mhsp_pkg::ROLE_STRBYTE;
                    count_next = count_dec;
                    if (count_dec == '0)
                        nxt = after_string(type_reg, flags_reg[2:1]);
                end
                PH_LEVEL:
                begin
                    role = mhsp_pkg::ROLE_LEVEL;
                    nxt  = PH_CFLAGS;
                end
                PH_CFLAGS:
                begin
                    role       = mhsp_pkg::ROLE_CFLAGS;
                    count_next = '0;
                    nxt        = PH_KA;
                end
                PH_KA:
                begin
                    role = mhsp_pkg::ROLE_KEEPALIVE;
                    if (count_reg == '0)
                    begin
                        ka_next    = {in_byte, 8'd0};
                        count_next = 16'd1;
                    end
                    else
                    begin
                        ka_next    = {ka_reg[15:8], in_byte};
                        count_next = '0;
                        nxt        = PH_PAYLOAD;
                    end
                end
                PH_ID:
                begin
                    role = mhsp_pkg::ROLE_ID;
                    if (count_reg == '0)
                    begin
                        id_next    = {in_byte, 8'd0};
                        count_next = 16'd1;
                    end
                    else
                    begin
                        id_next    = {id_reg[15:8], in_byte};
                        count_next = '0;
                        nxt        = PH_PAYLOAD;
                    end
                end
                PH_CONNACK:
                begin
                    role = mhsp_pkg::ROLE_CONNACK;
                    if (count_reg == '0)
                        count_next = 16'd1;
                    else
                    begin
                        count_next = '0;
                        nxt        = PH_PAYLOAD;
                    end
                end
                PH_SKIP:
                begin
                    role = mhsp_pkg::ROLE_PAYLOAD;
                    err  = mhsp_pkg::ERR_STR_OVER;
                end
                default:
                begin
                    role = mhsp_pkg::ROLE_PAYLOAD;
                end
            endcase
            // packet ends here; flag a header that never completed
            if (left_dec == '0)
            begin
                last = 1'b1;
                if (err == mhsp_pkg::ERR_NONE && nxt >= PH_STRLEN && nxt <= PH_CONNACK)
                    err = mhsp_pkg::ERR_HDR_SHORT;
                count_next = '0;
                nxt        = PH_FIRST;
            end
            phase_next = nxt;
        end
        else
        begin
            role        = mhsp_pkg::ROLE_FIRST;
            type_next   = in_byte[7:4];
            flags_next  = in_byte[3:0];
            total_next  = '0;
            shift_next  = '0;
            count_next  = '0;
            strlen_next = '0;
            id_next     = '0;
            ka_next     = '0;
            phase_next  = PH_LEN;
        end
    end

    always_comb
    begin
        res.data_byte        = in_byte;
        res.byte_role        = role;
        res.packet_type      = type_next;
        res.packet_flags     = flags_next;
        res.remaining_length = total_next;
        res.string_length    = strlen_next;
        res.packet_id        = id_next;
        res.keepalive        = ka_next;
        res.last_of_packet   = last;
        res.error_code       = err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_FIRST;
            type_reg   <= '0;
            flags_reg  <= '0;
            left_reg   <= '0;
            shift_reg  <= '0;
            count_reg  <= '0;
            strlen_reg <= '0;
            id_reg     <= '0;
            ka_reg     <= '0;
            stuck_reg  <= 1'b0;
            total_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            flags_reg  <= flags_next;
            left_reg   <= left_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            strlen_reg <= strlen_next;
            id_reg     <= id_next;
            ka_reg     <= ka_next;
            stuck_reg  <= stuck_next;
            total_reg  <= total_next;
        end
    end

endmodule

/* hdl/mqtt_header_stream_parser_top.sv */
// MQTT header stream parser: top level with byte input and tagged result register.
//
// Input channel: in_valid / in_stall / in_byte, one stream byte per beat.
// Output channel: out_valid / out_stall and one port per result field; every
// input byte yields exactly one output beat carrying the byte, its role in the
// packet, the packet's type and flags, the decoded remaining length, header
// string length, packet id, keepalive, an end-of-packet mark and an error code.
// A byte accepted at one edge is presented on the output from the next cycle.
// One byte per cycle while in_stall is low; the decode of a byte against the
// parser state is a single pass of logic into the result register.
// in_stall is raised only while a result is held and the receiver stalls, so
// the parser keeps taking bytes whenever the result register is being drained.
// A stalled result holds its fields steady until taken.
// Reset clears the parser to wait for a packet's first byte and empties the
// result register. A fifth length byte locks the parser into a length error
// until the next reset.
module mqtt_header_stream_parser_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic [3:0]  byte_role,
    output logic [3:0]  packet_type,
    output logic [3:0]  packet_flags,
    output logic [27:0] remaining_length,
    output logic [15:0] string_length,
    output logic [15:0] packet_id,
    output logic [15:0] keepalive,
    output logic        last_of_packet,
    output logic [1:0]  error_code
);

    mhsp_pkg::result_t res;
    mhsp_pkg::result_t res_reg;
    logic              valid_reg, valid_next;
    logic              accept;

    assign in_stall = valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    mhsp_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (accept),
        .in_byte (in_byte),
        .res     (res)
    );

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (out_stall)
            valid_next = valid_reg;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= res;
    end

    assign out_valid        = valid_reg;
    assign data_byte        = res_reg.data_byte;
    assign byte_role        = res_reg.byte_role;
    assign packet_type      = res_reg.packet_type;
    assign packet_flags     = res_reg.packet_flags;
    assign remaining_length = res_reg.remaining_length;
    assign string_length    = res_reg.string_length;
    assign packet_id        = res_reg.packet_id;
    assign keepalive        = res_reg.keepalive;
    assign last_of_packet   = res_reg.last_of_packet;
    assign error_code       = res_reg.error_code;

endmodule

/* hdl/mhsp_checker.sv */
// Port-level checks for the MQTT header stream parser, bound to the top level.
module mhsp_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  byte_role,
    input  logic [27:0] remaining_length,
    input  logic        last_of_packet,
    input  logic [1:0]  error_code
);

    // a held result stays up
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // an accepted byte comes out with itself on the next beat
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid && data_byte == $past(in_byte))
        else $error("accepted byte not presented next cycle");

    // a first byte starts clean
    a_first_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == mhsp_pkg::ROLE_FIRST |->
            error_code == mhsp_pkg::ERR_NONE && !last_of_packet && remaining_length == '0)
        else $error("first byte carries stale length or error");

    // the locked length error never closes a packet
    a_len_err_open: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_code == mhsp_pkg::ERR_LEN_LONG |->
            !last_of_packet && byte_role == mhsp_pkg::ROLE_LENGTH)
        else $error("length error beat marked as packet end");

endmodule

bind mqtt_header_stream_parser_top mhsp_checker u_mhsp_checker (.*);

/* test/testbench.sv */
// Self-checking testbench for the MQTT header stream parser: random stream, predictor, checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_AT    = 400;
    localparam int HOLD_LEN   = 400;

    typedef enum logic [3:0]
    {
        W_FIRST, W_LEN, W_LENX, W_STRLEN, W_STR, W_LEVEL, W_CFLAGS,
        W_KA, W_ID, W_CONNACK, W_PAYLOAD, W_SKIP
    } walk_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  data_byte;
    logic [3:0]  byte_role;
    logic [3:0]  packet_type;
    logic [3:0]  packet_flags;
    logic [27:0] remaining_length;
    logic [15:0] string_length;
    logic [15:0] packet_id;
    logic [15:0] keepalive;
    logic        last_of_packet;
    logic [1:0]  error_code;

    // parser state as the predictor sees it
    walk_t       walk;
    logic [3:0]  pk_type;
    logic [3:0]  pk_flags;
    logic [27:0] left_cnt;
    logic [1:0]  len_shift;
    logic [15:0] fld_cnt;
    logic [15:0] str_len;
    logic [15:0] id_reg;
    logic [15:0] ka_reg;
    logic        len_locked;
    logic [27:0] len_sum;

    logic [7:0]        stream_bytes[$];
    mhsp_pkg::result_t due_results[$];

    int pause_idx = -1;
    int fed;
    int sent_cnt;
    int burst_left;
    int gap_left;
    int taken;
    int hold_left;
    int stall_pct;
    int pat_cnt;
    int idle_cycles = 0;
    int fail_cnt = 0;

    mqtt_header_stream_parser_top DUT
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_byte(in_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .data_byte(data_byte),
        .byte_role(byte_role),
        .packet_type(packet_type),
        .packet_flags(packet_flags),
        .remaining_length(remaining_length),
        .string_length(string_length),
        .packet_id(packet_id),
        .keepalive(keepalive),
        .last_of_packet(last_of_packet),
        .error_code(error_code)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic walk_t string_done();
        if (pk_type == mhsp_pkg::PT_CONNECT)
            return W_LEVEL;
        if (pk_flags[2:1] != 2'b00)
            return W_ID;
        return W_PAYLOAD;
    endfunction

    function automatic mhsp_pkg::result_t parse_byte(input logic [7:0] b);
        mhsp_pkg::result_t r;
        walk_t             nxt;
        logic [31:0]       acc;
        r.byte_role      = mhsp_pkg::ROLE_PAYLOAD;
        r.error_code     = mhsp_pkg::ERR_NONE;
        r.last_of_packet = 1'b0;
        if (len_locked)
        begin
            r.byte_role  = mhsp_pkg::ROLE_LENGTH;
            r.error_code = mhsp_pkg::ERR_LEN_LONG;
        end
        else if (walk == W_FIRST)
        begin
            r.byte_role = mhsp_pkg::ROLE_FIRST;
            pk_type   = b[7:4];
            pk_flags  = b[3:0];
            len_sum   = '0;
            len_shift = '0;
            fld_cnt   = '0;
            str_len   = '0;
            id_reg    = '0;
            ka_reg    = '0;
            walk      = W_LEN;
        end
        else if (walk == W_LEN)
        begin
            r.byte_role = mhsp_pkg::ROLE_LENGTH;
            acc = {4'h0, len_sum} + ({25'h0, b[6:0]} << (7 * len_shift));
            len_sum = acc[27:0];
            if (b[7])
            begin
                if (len_shift == 2'd3)
                    walk = W_LENX;
                else
                    len_shift++;
            end
            else
            begin
                left_cnt = len_sum;
                fld_cnt  = '0;
                if (left_cnt == 0)
                begin
                    r.last_of_packet = 1'b1;
                    if (pk_type >= mhsp_pkg::PT_CONNECT && pk_type <= mhsp_pkg::PT_UNSUBACK)
                        r.error_code = mhsp_pkg::ERR_HDR_SHORT;
                    walk = W_FIRST;
                end
                else if (pk_type == mhsp_pkg::PT_CONNECT || pk_type == mhsp_pkg::PT_PUBLISH)
                    walk = W_STRLEN;
                else if (pk_type == mhsp_pkg::PT_CONNACK)
                    walk = W_CONNACK;
                else if (pk_type >= mhsp_pkg::PT_PUBACK && pk_type <= mhsp_pkg::PT_UNSUBACK)
                    walk = W_ID;
                else
                    walk = W_PAYLOAD;
            end
        end
        else if (walk == W_LENX)
        begin
            r.byte_role  = mhsp_pkg::ROLE_LENGTH;
            r.error_code = mhsp_pkg::ERR_LEN_LONG;
            len_locked   = 1'b1;
        end
        else
        begin
            left_cnt = (left_cnt != 0) ? left_cnt - 28'd1 : '0;
            nxt = walk;
            case (walk)
                W_STRLEN:
                begin
                    r.byte_role = mhsp_pkg::ROLE_STRLEN;
                    if (fld_cnt == 0)
                    begin
                        str_len = {b, 8'h00};
                        fld_cnt = 16'd1;
                    end
                    else
                    begin
                        str_len[7:0] = b;
                        fld_cnt = '0;
                        if ({12'h0, str_len} > left_cnt)
                        begin
                            r.error_code = mhsp_pkg::ERR_STR_OVER;
                            nxt = W_SKIP;
                        end
                        else if (str_len != 0)
                        begin
                            fld_cnt = str_len;
                            nxt = W_STR;
                        end
                        else
                            nxt = string_done();
                    end
                end
                W_STR:
                begin
                    r.byte_role = mhsp_pkg::ROLE_STRBYTE;
                    if (fld_cnt != 0)
                        fld_cnt--;
                    if (fld_cnt == 0)
                        nxt = string_done();
                end
                W_LEVEL:
                begin
                    r.byte_role = mhsp_pkg::ROLE_LEVEL;
                    nxt = W_CFLAGS;
                end
                W_CFLAGS:
                begin
                    r.byte_role = mhsp_pkg::ROLE_CFLAGS;
                    fld_cnt = '0;
                    nxt = W_KA;
                end
                W_KA:
                begin
                    r.byte_role = mhsp_pkg::ROLE_KEEPALIVE;
                    if (fld_cnt == 0)
                    begin
                        ka_reg  = {b, 8'h00};
                        fld_cnt = 16'd1;
                    end
                    else
                    begin
                        ka_reg[7:0] = b;
                        fld_cnt = '0;
                        nxt = W_PAYLOAD;
                    end
                end
                W_ID:
                begin
                    r.byte_role = mhsp_pkg::ROLE_ID;
                    if (fld_cnt == 0)
                    begin
                        id_reg  = {b, 8'h00};
                        fld_cnt = 16'd1;
                    end
                    else
                    begin
                        id_reg[7:0] = b;
                        fld_cnt = '0;
                        nxt = W_PAYLOAD;
                    end
                end
                W_CONNACK:
                begin
                    r.byte_role = mhsp_pkg::ROLE_CONNACK;
                    if (fld_cnt == 0)
                        fld_cnt = 16'd1;
                    else
                    begin
                        fld_cnt = '0;
                        nxt = W_PAYLOAD;
                    end
                end
                W_SKIP:
                begin
                    r.byte_role  = mhsp_pkg::ROLE_PAYLOAD;
                    r.error_code = mhsp_pkg::ERR_STR_OVER;
                end
                default:
                    r.byte_role = mhsp_pkg::ROLE_PAYLOAD;
            endcase
            if (left_cnt == 0)
            begin
                r.last_of_packet = 1'b1;
                // packet ran out while a header field was still owed
                if (r.error_code == mhsp_pkg::ERR_NONE && nxt >= W_STRLEN && nxt <= W_CONNACK)
                    r.error_code = mhsp_pkg::ERR_HDR_SHORT;
                fld_cnt = '0;
                nxt = W_FIRST;
            end
            walk = nxt;
        end
        r.data_byte        = b;
        r.packet_type      = pk_type;
        r.packet_flags     = pk_flags;
        r.remaining_length = len_sum;
        r.string_length    = str_len;
        r.packet_id        = id_reg;
        r.keepalive        = ka_reg;
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [27:0] want,
                                        input logic [27:0] got);
        if (want !== got)
        begin
            fail_cnt++;
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    // stimulus: directed packets, random packets, then the sticky length error last
    initial
    begin
        int          kind;
        int          n;
        int          ngroups;
        logic [3:0]  ptype;
        logic [3:0]  pflags;
        logic [7:0]  body[$];
        logic [27:0] plen;
        logic [7:0]  name_len;

        // zero-length CONNECT (header too short), zero-length PINGREQ
        stream_bytes = '{8'h10, 8'h00, 8'hc0, 8'h00};
        // CONNACK
        stream_bytes = {stream_bytes, 8'h20, 8'h02, 8'h00, 8'h00};
        // PUBLISH qos 3, empty topic, id all ones
        stream_bytes = {stream_bytes, 8'h36, 8'h04, 8'h00, 8'h00, 8'hff, 8'hff};
        // topic length far beyond the packet
        stream_bytes = {stream_bytes, 8'h30, 8'h03, 8'hff, 8'hff, 8'h00};
        // SUBSCRIBE ending inside its packet id
        stream_bytes = {stream_bytes, 8'h82, 8'h01, 8'hab};

        while (stream_bytes.size() < 1430)
        begin
            if (pause_idx < 0 && stream_bytes.size() >= 700)
                pause_idx = stream_bytes.size();
            kind   = $urandom_range(0, 99);
            ptype  = 4'($urandom_range(0, 15));
            pflags = 4'($urandom_range(0, 15));
            body.delete();
            if (kind < 88)
            begin
                case (ptype)
                    mhsp_pkg::PT_CONNECT:
                    begin
                        name_len = 8'($urandom_range(0, 6));
                        body.push_back(8'h00);
                        body.push_back(name_len);
                        repeat (name_len + 4)
                            body.push_back(8'($urandom_range(0, 255)));
                    end
                    mhsp_pkg::PT_CONNACK:
                        repeat (2) body.push_back(8'($urandom_range(0, 255)));
                    mhsp_pkg::PT_PUBLISH:
                    begin
                        name_len = 8'($urandom_range(0, 8));
                        body.push_back(8'h00);
                        body.push_back(name_len);
                        repeat (name_len) body.push_back(8'($urandom_range(0, 255)));
                        if (pflags[2:1] != 2'b00)
                            repeat (2) body.push_back(8'($urandom_range(0, 255)));
                    end
                    4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11:
                        repeat (2) body.push_back(8'($urandom_range(0, 255)));
                    default:
                        ;
                endcase
                n = ($urandom_range(0, 29) == 0) ? $urandom_range(100, 200)
                                                 : $urandom_range(0, 10);
                repeat (n) body.push_back(8'($urandom_range(0, 255)));
                // some packets cut short
                if (kind >= 75 && body.size() > 0)
                begin
                    n = $urandom_range(0, body.size() - 1);
                    body = body[0:n - 1];
                end
            end
            else
                repeat ($urandom_range(0, 20)) body.push_back(8'($urandom_range(0, 255)));

            plen = 28'(body.size());
            ngroups = 1;
            while (ngroups < 4 && (plen >> (7 * ngroups)) != 0)
                ngroups++;
            // non-minimal length encodings now and then
            if ($urandom_range(0, 14) == 0)
                ngroups = $urandom_range(ngroups, 4);
            stream_bytes.push_back({ptype, pflags});
            for (int i = 0; i < ngroups; i++)
                stream_bytes.push_back({i < ngroups - 1, plen[7 * i +: 7]});
            stream_bytes = {stream_bytes, body};
        end

        // four continuation bytes of all ones, then a fifth: locks the parser
        stream_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (4) stream_bytes.push_back(8'hff);
        repeat (6) stream_bytes.push_back(8'($urandom_range(0, 255)));

        n = stream_bytes.size();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (sent_cnt < n)
            @(posedge clk);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_cnt == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // sender: bursts and gaps, one pause until all results are back
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_byte    <= 8'h00;
            fed        = 0;
            sent_cnt   = 0;
            burst_left = 20;
            gap_left   = 0;
            walk       = W_FIRST;
            pk_type    = '0;
            pk_flags   = '0;
            left_cnt   = '0;
            len_shift  = '0;
            fld_cnt    = '0;
            str_len    = '0;
            id_reg     = '0;
            ka_reg     = '0;
            len_locked = 1'b0;
            len_sum    = '0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                due_results.push_back(parse_byte(in_byte));
                sent_cnt++;
            end
            if (!in_valid || !in_stall)
            begin
                if (stream_bytes.size() == 0 || (fed == pause_idx && due_results.size() != 0))
                    in_valid <= 1'b0;
                else if (gap_left != 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_byte  <= stream_bytes.pop_front();
                    fed++;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end
        end
    end

    // receiver: checks each beat, stalls on a shifting duty, one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        mhsp_pkg::result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            taken     = 0;
            hold_left = 0;
            stall_pct = 0;
            pat_cnt   = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    fail_cnt++;
                    $display("%0t ns: result with nothing expected, data_byte 0x%0h",
                             $time, data_byte);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("data_byte", 28'(want.data_byte), 28'(data_byte));
                    check_field("byte_role", 28'(want.byte_role), 28'(byte_role));
                    check_field("packet_type", 28'(want.packet_type), 28'(packet_type));
                    check_field("packet_flags", 28'(want.packet_flags), 28'(packet_flags));
                    check_field("remaining_length", want.remaining_length, remaining_length);
                    check_field("string_length", 28'(want.string_length),
                                28'(string_length));
                    check_field("packet_id", 28'(want.packet_id), 28'(packet_id));
                    check_field("keepalive", 28'(want.keepalive), 28'(keepalive));
                    check_field("last_of_packet", 28'(want.last_of_packet),
                                28'(last_of_packet));
                    check_field("error_code", 28'(want.error_code), 28'(error_code));
                end
                taken++;
                if (taken == HOLD_AT)
                    hold_left = HOLD_LEN;
            end
            pat_cnt++;
            if (pat_cnt % 97 == 0)
                case ($urandom_range(0, 4))
                    0, 1: stall_pct = 0;
                    2: stall_pct = 25;
                    3: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

endmodule

/* filelist.f */
hdl/mhsp_pkg.sv
hdl/mhsp_core.sv
hdl/mqtt_header_stream_parser_top.sv
hdl/mhsp_checker.sv
test/testbench.sv
